>>> rtl/core/special_colour_blend_core_defines.svh
// Assertion macros for the colour blend core.
`ifndef SPECIAL_COLOUR_BLEND_CORE_DEFINES_SVH
`define SPECIAL_COLOUR_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/scb_pkg.sv
// Types, mode codes and color tables for the colour blend core.
`default_nettype none

package scb_pkg;

   // Pixel transfer types
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } pixel_out_type;

   // Blend mode codes
   localparam logic [5:0] MODE_ICE        = 6'd0;
   localparam logic [5:0] MODE_DESAT_LAST = 6'd31;
   localparam logic [5:0] MODE_INVERSE    = 6'd32;
   localparam logic [5:0] MODE_RED        = 6'd33;
   localparam logic [5:0] MODE_GOLD       = 6'd36;
   localparam logic [5:0] MODE_PASS       = 6'd37;

   // Luma weights, sum 257
   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd143;
   localparam logic [7:0] LUMA_B = 8'd37;

   // floor(x/31) == (x*8457)>>18 for all x below 31*256
   localparam logic [13:0] RECIP_31    = 14'd8457;
   localparam int          RECIP_SHIFT = 18;

   // Inverse gradient: level is (65280 - grey) / 256, floored at zero
   localparam logic [15:0] INVERSE_TOP = 16'd65280;

   // Ice palette, {r, g, b}
   localparam logic [23:0] ICE_TABLE [16] = '{
      24'h0A0812, 24'h0F0F1A, 24'h141024, 24'h1E1A2E,
      24'h282439, 24'h322E43, 24'h3B394E, 24'h454358,
      24'h4F4D63, 24'h59576D, 24'h636178, 24'h6D6B82,
      24'h76768D, 24'h808097, 24'h8A8AA2, 24'h9494AC
   };

   // Gradient end points in quarter steps, {r, g, b}, for red, green, blue, gold
   localparam logic [8:0] GRAD_END [4] = '{
      {3'd6, 3'd0, 3'd0},
      {3'd5, 3'd6, 3'd4},
      {3'd0, 3'd0, 3'd6},
      {3'd6, 3'd3, 3'd0}
   };

   // Gradient from black: grey * end / 1024, saturated to a byte
   function automatic logic [7:0] grad_level(input logic [15:0] grey, input logic [2:0] q_end);
      logic [18:0] prod;
      prod = 19'(grey) * 19'(q_end);
      grad_level = (prod[18] != 1'b0) ? 8'hFF : prod[17:10];
   endfunction

   // Gradient from white to black
   function automatic logic [7:0] inverse_level(input logic [15:0] grey);
      logic [15:0] diff;
      diff = INVERSE_TOP - grey;
      inverse_level = (grey > INVERSE_TOP) ? 8'd0 : diff[15:8];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/special_colour_blend_core.sv
// Colour blend core: five-stage pipeline, one pixel per clock.
`default_nettype none

// One RGB pixel enters per clock (start while busy is low; busy is never
// raised) and its blended pixel appears on rsp_pixel with a one-cycle
// rsp_strobe. The pipeline stages are capture, luma, channel mix,
// reciprocal multiply for the divide by 31, and the output register.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// The blend mode is sampled with each pixel at capture; csr_ready is high only
// while the pipeline is empty and no pixel is offered, so mode changes never
// split in-flight pixels.
// Reset selects passthrough.
module special_colour_blend_core
   import scb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // pixel input
   input  wire logic          start,
   output      logic          busy,
   input  wire pixel_in_type  req_pixel,
   // pixel output
   output      logic          rsp_strobe,
   output      pixel_out_type rsp_pixel,
   // mode register
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [5:0]    csr_data
);

`include "special_colour_blend_core_defines.svh"

   // Mode register
   logic [5:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   // Stage 1: capture
   logic         s1_valid_ff;
   pixel_in_type s1_pixel_ff;
   logic [5:0]   s1_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= req_pixel;
      s1_mode_ff  <= mode_ff;
   end

   // Stage 2: luma, 8 fraction bits
   logic         s2_valid_ff;
   pixel_in_type s2_pixel_ff;
   logic [5:0]   s2_mode_ff;
   logic [15:0]  s2_grey_ff;
   logic [15:0]  s2_grey_in;

   always_comb begin
      s2_grey_in = 16'(16'(s1_pixel_ff.red_in) * 16'(LUMA_R))
                 + 16'(16'(s1_pixel_ff.green_in) * 16'(LUMA_G))
                 + 16'(16'(s1_pixel_ff.blue_in) * 16'(LUMA_B));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_pixel_ff <= s1_pixel_ff;
      s2_mode_ff  <= s1_mode_ff;
      s2_grey_ff  <= s2_grey_in;
   end

   // Stage 3: desaturate mix (divided by 256) and the table/gradient paths
   logic          s3_valid_ff;
   logic          s3_desat_ff;
   logic          s3_desat_in;
   logic [12:0]   s3_mix_ff [3];
   logic [12:0]   s3_mix_in [3];
   pixel_out_type s3_alt_ff;
   pixel_out_type s3_alt_in;
   logic [4:0]    s3_wt_grey;
   logic [4:0]    s3_wt_chan;
   logic [7:0]    s3_chan [3];
   logic [20:0]   s3_sum [3];
   logic [23:0]   s3_ice;
   logic [8:0]    s3_ends;
   logic [1:0]    s3_preset;

   assign s3_chan[0] = s2_pixel_ff.red_in;
   assign s3_chan[1] = s2_pixel_ff.green_in;
   assign s3_chan[2] = s2_pixel_ff.blue_in;

   always_comb begin
      s3_desat_in = (s2_mode_ff != MODE_ICE) && (s2_mode_ff <= MODE_DESAT_LAST);
      // grey weight mode-1, channel weight 32-mode
      s3_wt_grey  = 5'(s2_mode_ff - 6'd1);
      s3_wt_chan  = 5'(6'd32 - s2_mode_ff);
      for (int k = 0; k < 3; k++) begin
         s3_sum[k]    = 21'({13'(13'(s3_chan[k]) * 13'(s3_wt_chan)), 8'd0})
                      + 21'(21'(s2_grey_ff) * 21'(s3_wt_grey));
         s3_mix_in[k] = s3_sum[k][20:8];
      end
   end

   always_comb begin
      s3_ice    = ICE_TABLE[s2_grey_ff[15:12]];
      s3_preset = 2'(s2_mode_ff - MODE_RED);
      s3_ends   = GRAD_END[s3_preset];
      case (s2_mode_ff) inside
         MODE_ICE: begin
            s3_alt_in = pixel_out_type'(s3_ice);
         end
         MODE_INVERSE: begin
            s3_alt_in.red_out   = inverse_level(s2_grey_ff);
            s3_alt_in.green_out = inverse_level(s2_grey_ff);
            s3_alt_in.blue_out  = inverse_level(s2_grey_ff);
         end
         [MODE_RED:MODE_GOLD]: begin
            s3_alt_in.red_out   = grad_level(s2_grey_ff, s3_ends[8:6]);
            s3_alt_in.green_out = grad_level(s2_grey_ff, s3_ends[5:3]);
            s3_alt_in.blue_out  = grad_level(s2_grey_ff, s3_ends[2:0]);
         end
         default: begin
            s3_alt_in.red_out   = s2_pixel_ff.red_in;
            s3_alt_in.green_out = s2_pixel_ff.green_in;
            s3_alt_in.blue_out  = s2_pixel_ff.blue_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_desat_ff <= s3_desat_in;
      s3_alt_ff   <= s3_alt_in;
      for (int k = 0; k < 3; k++) begin
         s3_mix_ff[k] <= s3_mix_in[k];
      end
   end

   // Stage 4: reciprocal multiply for the divide by 31
   logic          s4_valid_ff;
   logic          s4_desat_ff;
   logic [25:0]   s4_prod_ff [3];
   pixel_out_type s4_alt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_desat_ff <= s3_desat_ff;
      s4_alt_ff   <= s3_alt_ff;
      for (int k = 0; k < 3; k++) begin
         s4_prod_ff[k] <= 26'(26'(s3_mix_ff[k]) * 26'(RECIP_31));
      end
   end

   // Stage 5: quotient select and output register
   logic          rsp_strobe_ff;
   pixel_out_type rsp_pixel_ff;
   pixel_out_type rsp_pixel_in;

   always_comb begin
      if (s4_desat_ff) begin
         rsp_pixel_in.red_out   = s4_prod_ff[0][RECIP_SHIFT +: 8];
         rsp_pixel_in.green_out = s4_prod_ff[1][RECIP_SHIFT +: 8];
         rsp_pixel_in.blue_out  = s4_prod_ff[2][RECIP_SHIFT +: 8];
      end else begin
         rsp_pixel_in = s4_alt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // Ports
   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_pixel  = rsp_pixel_ff;
   assign csr_ready  = !(start || s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff
                         || rsp_strobe_ff);

   // Checks
   `SCB_ASSERT_NOW(a_cfg_only_when_empty, clock, reset, rsp_strobe, !csr_ready,
      "mode register open while a transfer is in flight")
   `SCB_ASSERT_NOW(a_pass_identity, clock, reset,
      rsp_strobe && ($past(s1_mode_ff, 4) >= MODE_PASS),
      rsp_pixel == pixel_out_type'($past(s1_pixel_ff, 4)),
      "passthrough pixel altered")
   `SCB_ASSERT_NOW(a_desat_zero_identity, clock, reset,
      rsp_strobe && ($past(s1_mode_ff, 4) == 6'd1),
      rsp_pixel == pixel_out_type'($past(s1_pixel_ff, 4)),
      "zero-amount desaturate altered pixel")
   `SCB_ASSERT_NEXT(a_strobe_follows, clock, reset, s4_valid_ff, rsp_strobe,
      "pipeline dropped a pixel at the output stage")

endmodule

`default_nettype wire
